### rtl/frx_pkg.sv
package frx_pkg;

  localparam int LENGTH_BITS_DEFAULT = 16;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_ADDRESS = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_TICKS = CFG_INDEX_W'(1);

  localparam logic [7:0]  FRAME_ADDRESS_RESET = 8'd0;
  localparam logic [15:0] TIMEOUT_RESET       = 16'd1000;
  localparam logic [15:0] TICK_MAX            = 16'hffff;

  typedef enum logic [1:0] {
    REQ_BYTE    = 2'd0,
    REQ_TICK    = 2'd1,
    REQ_RELEASE = 2'd2
  } req_type_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic        byte_accepted;
    logic [15:0] byte_position;
    logic [7:0]  byte_value;
    logic        frame_done;
    logic        frame_aborted;
    logic        frame_ready;
  } result_t;

endpackage

### rtl/frx_in_if.sv
interface frx_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink (input valid, input req_type, input rx_byte, output ready);
endinterface

### rtl/frx_out_if.sv
interface frx_out_if;
  logic        valid;
  logic        ready;
  logic        byte_accepted;
  logic [15:0] byte_position;
  logic [7:0]  byte_value;
  logic        frame_done;
  logic        frame_aborted;
  logic        frame_ready;

  modport source (
    output valid, output byte_accepted, output byte_position, output byte_value,
    output frame_done, output frame_aborted, output frame_ready, input ready
  );
  modport sink (
    input valid, input byte_accepted, input byte_position, input byte_value,
    input frame_done, input frame_aborted, input frame_ready, output ready
  );
endinterface

### rtl/frx_cfg_if.sv
interface frx_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [frx_pkg::CFG_INDEX_W-1:0]   index;
  logic [frx_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/framed_serial_receiver_core.sv
// Address/length framed serial receiver. Each transaction on rx_in carries a
// received byte, a timer tick or a release request, and yields exactly one
// transaction on rx_out via the input and result registers. The block takes
// a new transaction every cycle while rx_out is not stalled: the per-item
// work is one pass of frame logic between the input register and the
// result register, and the frame state is updated as the item passes into
// the result register. Configuration writes on cfg are always taken (ready
// held high) and are meant to be done while no transaction is in flight.
module framed_serial_receiver_core #(
  parameter int LENGTH_BITS = frx_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  frx_in_if.sink     rx_in,
  frx_out_if.source  rx_out,
  frx_cfg_if.sink    cfg
);

  logic              item_valid;
  logic              can_load;
  logic              take;
  frx_pkg::item_t    item;
  frx_pkg::result_t  result;

  assign take = item_valid && can_load;

  frx_input_reg u_input_reg (
    .clk        (clk),
    .rst        (rst),
    .rx_in      (rx_in),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  frx_frame_ctrl #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_frame_ctrl (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .fire   (take),
    .item   (item),
    .result (result)
  );

  frx_output_reg u_output_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (take),
    .result   (result),
    .can_load (can_load),
    .rx_out   (rx_out)
  );

endmodule

### rtl/frx_input_reg.sv
module frx_input_reg (
  input  logic            clk,
  input  logic            rst,
  frx_in_if.sink          rx_in,
  input  logic            take,
  output logic            item_valid,
  output frx_pkg::item_t  item
);

  assign rx_in.ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (rx_in.ready) begin
      item_valid <= rx_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_in.valid && rx_in.ready) begin
      item.req_type <= rx_in.req_type;
      item.rx_byte  <= rx_in.rx_byte;
    end
  end

endmodule

### rtl/frx_frame_ctrl.sv
module frx_frame_ctrl #(
  parameter int LENGTH_BITS = frx_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  frx_cfg_if.sink           cfg,
  input  logic              fire,
  input  frx_pkg::item_t    item,
  output frx_pkg::result_t  result
);

  localparam int CMP_W = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;
  localparam logic [LENGTH_BITS-1:0] COUNT_MAX = '1;

  logic [7:0]             frame_address;
  logic [15:0]            timeout_ticks, timeout_ticks_next;
  logic                   in_frame, in_frame_next;
  logic                   length_known, length_known_next;
  logic [LENGTH_BITS-1:0] byte_count, byte_count_next;
  logic [7:0]             length_high, length_high_next;
  logic [15:0]            expected_length, expected_length_next;
  logic [15:0]            tick_count, tick_count_next;
  logic                   ready_flag, ready_flag_next;

  assign cfg.ready = 1'b1;

  always_comb begin
    in_frame_next        = in_frame;
    length_known_next    = length_known;
    byte_count_next      = byte_count;
    length_high_next     = length_high;
    expected_length_next = expected_length;
    tick_count_next      = tick_count;
    ready_flag_next      = ready_flag;
    timeout_ticks_next   = timeout_ticks;
    result               = '0;

    case (item.req_type)
      frx_pkg::REQ_BYTE: begin
        // address byte opens a frame
        if (!in_frame && item.rx_byte == frame_address) begin
          in_frame_next     = 1'b1;
          length_known_next = 1'b0;
          byte_count_next   = '0;
          tick_count_next   = '0;
        end
        if (in_frame_next) begin
          result.byte_accepted = 1'b1;
          result.byte_position = 16'(byte_count_next);
          result.byte_value    = item.rx_byte;
          if (!length_known_next && byte_count_next == LENGTH_BITS'(1)) begin
            length_high_next = item.rx_byte;
          end else if (!length_known_next && byte_count_next == LENGTH_BITS'(2)) begin
            expected_length_next = {length_high, item.rx_byte};
            length_known_next    = 1'b1;
          end
          if (byte_count_next != COUNT_MAX) begin
            byte_count_next = byte_count_next + LENGTH_BITS'(1);
          end
          if (length_known_next
              && CMP_W'(byte_count_next) == CMP_W'(expected_length_next)) begin
            result.frame_done = 1'b1;
            ready_flag_next   = 1'b1;
            in_frame_next     = 1'b0;
            length_known_next = 1'b0;
            byte_count_next   = '0;
          end
        end
      end
      frx_pkg::REQ_TICK: begin
        if (in_frame) begin
          if (tick_count > timeout_ticks) begin
            result.frame_aborted = 1'b1;
            in_frame_next        = 1'b0;
            length_known_next    = 1'b0;
            byte_count_next      = '0;
            expected_length_next = '0;
            tick_count_next      = '0;
            ready_flag_next      = 1'b0;
            timeout_ticks_next   = frx_pkg::TIMEOUT_RESET;
          end else if (tick_count != frx_pkg::TICK_MAX) begin
            tick_count_next = tick_count + 16'd1;
          end
        end
      end
      frx_pkg::REQ_RELEASE: begin
        ready_flag_next = 1'b0;
      end
      default: begin
      end
    endcase

    result.frame_ready = ready_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_address   <= frx_pkg::FRAME_ADDRESS_RESET;
      timeout_ticks   <= frx_pkg::TIMEOUT_RESET;
      in_frame        <= 1'b0;
      length_known    <= 1'b0;
      byte_count      <= '0;
      length_high     <= '0;
      expected_length <= '0;
      tick_count      <= '0;
      ready_flag      <= 1'b0;
    end else begin
      if (fire) begin
        in_frame        <= in_frame_next;
        length_known    <= length_known_next;
        byte_count      <= byte_count_next;
        length_high     <= length_high_next;
        expected_length <= expected_length_next;
        tick_count      <= tick_count_next;
        ready_flag      <= ready_flag_next;
      end
      if (cfg.valid && cfg.index == frx_pkg::REG_TIMEOUT_TICKS) begin
        timeout_ticks <= cfg.data[15:0];
      end else if (fire) begin
        timeout_ticks <= timeout_ticks_next;
      end
      if (cfg.valid && cfg.index == frx_pkg::REG_FRAME_ADDRESS) begin
        frame_address <= cfg.data[7:0];
      end
    end
  end

endmodule

### rtl/frx_output_reg.sv
module frx_output_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  frx_pkg::result_t  result,
  output logic              can_load,
  frx_out_if.source         rx_out
);

  frx_pkg::result_t data;

  assign can_load = !rx_out.valid || rx_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_out.valid <= 1'b0;
    end else if (can_load) begin
      rx_out.valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      data <= result;
    end
  end

  assign rx_out.byte_accepted = data.byte_accepted;
  assign rx_out.byte_position = data.byte_position;
  assign rx_out.byte_value    = data.byte_value;
  assign rx_out.frame_done    = data.frame_done;
  assign rx_out.frame_aborted = data.frame_aborted;
  assign rx_out.frame_ready   = data.frame_ready;

endmodule

### rtl/frx_checker.sv
module frx_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        byte_accepted,
  input logic [15:0] byte_position,
  input logic [7:0]  byte_value,
  input logic        frame_done,
  input logic        frame_aborted,
  input logic        frame_ready
);

  // a stalled result stays offered
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a completing byte is a frame byte and leaves the frame ready
  assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> byte_accepted && frame_ready && !frame_aborted)
    else $error("frame completion without accepted byte or ready flag");

  // an abort clears the ready flag and carries no byte
  assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_aborted |-> !byte_accepted && !frame_ready)
    else $error("abort with byte or ready flag");

  // byte fields are zero when no frame byte is reported
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_accepted |-> byte_position == 16'd0 && byte_value == 8'd0
      && !frame_done)
    else $error("byte fields set for a non-frame result");

  // a result appears only from an earlier input transaction
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without an input transaction");

endmodule

bind framed_serial_receiver_core frx_checker u_frx_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (rx_in.valid),
  .in_ready      (rx_in.ready),
  .out_valid     (rx_out.valid),
  .out_ready     (rx_out.ready),
  .byte_accepted (rx_out.byte_accepted),
  .byte_position (rx_out.byte_position),
  .byte_value    (rx_out.byte_value),
  .frame_done    (rx_out.frame_done),
  .frame_aborted (rx_out.frame_aborted),
  .frame_ready   (rx_out.frame_ready)
);

### tb/framed_serial_receiver_core_tb.sv
`timescale 1ns / 100ps

module framed_serial_receiver_core_tb;

  localparam logic [1:0] REQ_RESERVED = 2'd3;
  localparam logic [15:0] COUNT_MAX = {frx_pkg::LENGTH_BITS_DEFAULT{1'b1}};

  class frame_scoreboard;
    logic [7:0] frame_address;
    logic [15:0] timeout_ticks;
    bit in_frame;
    bit length_known;
    bit ready_flag;
    logic [15:0] byte_count;
    logic [15:0] expected_length;
    logic [15:0] tick_count;
    logic [7:0] length_high;
    frx_pkg::result_t expected_q[$];
    int errors;
    int checked;
    int frames_done;
    int frames_aborted;
    int bytes_in_frame;
    int cfg_writes;

    function new();
      frame_address = frx_pkg::FRAME_ADDRESS_RESET;
      timeout_ticks = frx_pkg::TIMEOUT_RESET;
      in_frame = 0;
      length_known = 0;
      ready_flag = 0;
      byte_count = '0;
      expected_length = '0;
      tick_count = '0;
      length_high = '0;
      errors = 0;
      checked = 0;
      frames_done = 0;
      frames_aborted = 0;
      bytes_in_frame = 0;
      cfg_writes = 0;
    endfunction

    function void write_reg(logic [frx_pkg::CFG_INDEX_W-1:0] idx,
                            logic [frx_pkg::CFG_DATA_W-1:0] data);
      cfg_writes++;
      if (idx == frx_pkg::REG_FRAME_ADDRESS) frame_address = data[7:0];
      else if (idx == frx_pkg::REG_TIMEOUT_TICKS) timeout_ticks = data[15:0];
    endfunction

    function frx_pkg::result_t predict(frx_pkg::item_t it);
      frx_pkg::result_t r;
      r = '0;
      case (it.req_type)
        frx_pkg::REQ_BYTE: begin
          if (!in_frame && it.rx_byte == frame_address) begin
            in_frame = 1;
            length_known = 0;
            byte_count = '0;
            tick_count = '0;
          end
          if (in_frame) begin
            r.byte_accepted = 1'b1;
            r.byte_position = byte_count;
            r.byte_value = it.rx_byte;
            if (!length_known && byte_count == 16'd1) begin
              length_high = it.rx_byte;
            end else if (!length_known && byte_count == 16'd2) begin
              expected_length = {length_high, it.rx_byte};
              length_known = 1;
            end
            if (byte_count != COUNT_MAX) byte_count = byte_count + 16'd1;
            if (length_known && byte_count == expected_length) begin
              r.frame_done = 1'b1;
              ready_flag = 1;
              in_frame = 0;
              length_known = 0;
              byte_count = '0;
            end
          end
        end
        frx_pkg::REQ_TICK: begin
          if (in_frame) begin
            if (tick_count > timeout_ticks) begin
              r.frame_aborted = 1'b1;
              in_frame = 0;
              length_known = 0;
              byte_count = '0;
              expected_length = '0;
              tick_count = '0;
              ready_flag = 0;
              timeout_ticks = frx_pkg::TIMEOUT_RESET;
            end else if (tick_count != frx_pkg::TICK_MAX) begin
              tick_count = tick_count + 16'd1;
            end
          end
        end
        frx_pkg::REQ_RELEASE: ready_flag = 0;
        default: ;
      endcase
      r.frame_ready = ready_flag;
      return r;
    endfunction

    function void note_input(frx_pkg::item_t it);
      expected_q.push_back(predict(it));
    endfunction

    function void cmp_field(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
      end
    endfunction

    function void check_result(frx_pkg::result_t act);
      frx_pkg::result_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction, expected none, actual %h", $time, act);
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (e.frame_done) frames_done++;
      if (e.frame_aborted) frames_aborted++;
      if (e.byte_accepted) bytes_in_frame++;
      cmp_field("byte_accepted", 32'(e.byte_accepted), 32'(act.byte_accepted));
      cmp_field("byte_position", 32'(e.byte_position), 32'(act.byte_position));
      cmp_field("byte_value", 32'(e.byte_value), 32'(act.byte_value));
      cmp_field("frame_done", 32'(e.frame_done), 32'(act.frame_done));
      cmp_field("frame_aborted", 32'(e.frame_aborted), 32'(act.frame_aborted));
      cmp_field("frame_ready", 32'(e.frame_ready), 32'(act.frame_ready));
    endfunction
  endclass

  logic clk;
  logic rst;
  logic hold_off;
  int src_idle;
  int snk_stall;
  int n_sent;
  logic [7:0] cur_address;
  frame_scoreboard sb;

  frx_in_if rx_in ();
  frx_out_if rx_out ();
  frx_cfg_if cfg ();

  framed_serial_receiver_core dut (
    .clk(clk),
    .rst(rst),
    .rx_in(rx_in),
    .rx_out(rx_out),
    .cfg(cfg)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk) begin
    rx_out.ready <= !hold_off && ($urandom_range(99) >= snk_stall);
  end

  always @(posedge clk) begin : monitor
    frx_pkg::item_t it;
    frx_pkg::result_t res;
    if (!rst) begin
      if (cfg.valid && cfg.ready) sb.write_reg(cfg.index, cfg.data);
      if (rx_in.valid && rx_in.ready) begin
        it.req_type = rx_in.req_type;
        it.rx_byte = rx_in.rx_byte;
        sb.note_input(it);
      end
      if (rx_out.valid && rx_out.ready) begin
        res.byte_accepted = rx_out.byte_accepted;
        res.byte_position = rx_out.byte_position;
        res.byte_value = rx_out.byte_value;
        res.frame_done = rx_out.frame_done;
        res.frame_aborted = rx_out.frame_aborted;
        res.frame_ready = rx_out.frame_ready;
        sb.check_result(res);
      end
    end
  end

  function frx_pkg::item_t make_item(logic [1:0] kind, logic [7:0] b);
    frx_pkg::item_t it;
    it.req_type = kind;
    it.rx_byte = b;
    return it;
  endfunction

  task send_item(input frx_pkg::item_t it);
    while ($urandom_range(99) < src_idle) begin
      rx_in.valid <= 1'b0;
      @(posedge clk);
    end
    rx_in.valid <= 1'b1;
    rx_in.req_type <= it.req_type;
    rx_in.rx_byte <= it.rx_byte;
    @(posedge clk);
    while (!rx_in.ready) @(posedge clk);
    n_sent++;
  endtask

  task send_byte(input logic [7:0] b);
    send_item(make_item(frx_pkg::REQ_BYTE, b));
  endtask

  task send_tick();
    send_item(make_item(frx_pkg::REQ_TICK, 8'($urandom())));
  endtask

  // wait until every transaction in flight has come back
  task drain();
    rx_in.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task write_reg(input logic [frx_pkg::CFG_INDEX_W-1:0] idx,
                 input logic [frx_pkg::CFG_DATA_W-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= data;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    @(posedge clk);
    if (idx == frx_pkg::REG_FRAME_ADDRESS) cur_address = data[7:0];
  endtask

  task sprinkle();
    int r;
    r = $urandom_range(99);
    if (r < 15) send_tick();
    else if (r < 18) send_item(make_item(frx_pkg::REQ_RELEASE, 8'($urandom())));
  endtask

  task send_noise();
    int n;
    int r;
    n = $urandom_range(0, 3);
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 45) send_byte(8'($urandom()));
      else if (r < 75) send_tick();
      else if (r < 95) send_item(make_item(frx_pkg::REQ_RELEASE, 8'($urandom())));
      else send_item(make_item(REQ_RESERVED, 8'($urandom())));
    end
    if ($urandom_range(99) < 20) repeat ($urandom_range(0, 10)) send_tick();
  endtask

  task send_frame();
    int r;
    int n_data;
    logic [15:0] flen;
    r = $urandom_range(99);
    if (r < 70) flen = 16'($urandom_range(3, 12));
    else if (r < 80) flen = 16'($urandom_range(0, 2));
    else if (r < 90) flen = 16'($urandom_range(13, 40));
    else flen = 16'($urandom());
    n_data = (flen > 3) ? flen - 3 : 0;
    if (n_data > 40) n_data = 40;
    if ($urandom_range(99) < 15) n_data = $urandom_range(0, n_data + 2);
    send_byte(cur_address);
    sprinkle();
    send_byte(flen[15:8]);
    sprinkle();
    send_byte(flen[7:0]);
    repeat (n_data) begin
      sprinkle();
      send_byte(8'($urandom()));
    end
  endtask

  initial begin : main
    int target;
    sb = new();
    rst = 1'b1;
    hold_off = 1'b0;
    src_idle = 0;
    snk_stall = 0;
    n_sent = 0;
    cur_address = frx_pkg::FRAME_ADDRESS_RESET;
    rx_in.valid = 1'b0;
    rx_in.req_type = frx_pkg::REQ_BYTE;
    rx_in.rx_byte = 8'h00;
    rx_out.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = frx_pkg::REG_FRAME_ADDRESS;
    cfg.data = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: idle corner cases, then frames at the reset address
    send_tick();
    send_item(make_item(frx_pkg::REQ_RELEASE, 8'h00));
    send_item(make_item(REQ_RESERVED, 8'hff));
    send_byte(8'h55);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h05);
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h04);
    send_byte(8'haa);
    send_item(make_item(frx_pkg::REQ_RELEASE, 8'h00));
    drain();
    write_reg(frx_pkg::REG_FRAME_ADDRESS, 16'hab_ff);
    write_reg(frx_pkg::REG_TIMEOUT_TICKS, 16'd0);
    send_byte(8'hff);
    send_byte(8'h00);
    send_byte(8'h01);
    send_tick();
    send_tick();
    send_tick();
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle <= 0; snk_stall <= 0; end
        1: begin src_idle <= 50; snk_stall <= 0; end
        2: begin src_idle <= 0; snk_stall <= 50; end
        default: begin src_idle <= 14; snk_stall <= 14; end
      endcase
      write_reg(frx_pkg::REG_FRAME_ADDRESS, {8'($urandom()), 8'($urandom())});
      case (ph)
        0: write_reg(frx_pkg::REG_TIMEOUT_TICKS, 16'($urandom_range(4, 40)));
        1: write_reg(frx_pkg::REG_TIMEOUT_TICKS, 16'hffff);
        2: write_reg(frx_pkg::REG_TIMEOUT_TICKS, 16'($urandom_range(0, 10)));
        default: write_reg(frx_pkg::REG_TIMEOUT_TICKS, 16'($urandom()));
      endcase
      if (ph == 0) begin
        fork
          begin
            hold_off <= 1'b1;
            repeat (300) @(posedge clk);
            hold_off <= 1'b0;
          end
        join_none
      end
      target = n_sent + 375;
      while (n_sent < target) begin
        send_noise();
        send_frame();
      end
      drain();
    end

    repeat (10) @(posedge clk);
    $display("tb: %0d transactions checked, %0d frame bytes, %0d config writes",
             sb.checked, sb.bytes_in_frame, sb.cfg_writes);
    $display("tb: %0d frames completed, %0d aborted, four handshake pacing phases",
             sb.frames_done, sb.frames_aborted);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### sim.f
rtl/frx_pkg.sv
rtl/frx_in_if.sv
rtl/frx_out_if.sv
rtl/frx_cfg_if.sv
rtl/frx_input_reg.sv
rtl/frx_frame_ctrl.sv
rtl/frx_output_reg.sv
rtl/framed_serial_receiver_core.sv
rtl/frx_checker.sv
tb/framed_serial_receiver_core_tb.sv
